FILE: hw/rtl/idn_pkg.sv
// idn_pkg: shared types, constants and helpers for the identifier normalizer.
// No dependencies; every other file of the block imports it, except idn_ram.
package idn_pkg;

    localparam int MAX_LEN = 64;
    localparam int ADDR_W  = $clog2(MAX_LEN);
    localparam int CNT_W   = $clog2(MAX_LEN + 1);

    localparam int Q_DEPTH = 2;
    localparam int Q_AW    = $clog2(Q_DEPTH);
    localparam int Q_CW    = $clog2(Q_DEPTH + 1);

    localparam int UNNAMED_LEN = 7;

    // input kinds
    localparam logic [1:0] KIND_CHAR  = 2'd0;
    localparam logic [1:0] KIND_FINAL = 2'd1;
    localparam logic [1:0] KIND_END   = 2'd2;
    localparam logic [1:0] KIND_RSVD  = 2'd3;

    // configuration register indexes
    localparam logic [1:0] CFG_CLASS = 2'd0;
    localparam logic [1:0] CFG_LOWER = 2'd1;
    localparam logic [1:0] CFG_EMPTY = 2'd2;
    localparam logic [1:0] CFG_LIMIT = 2'd3;

    // class enable bits
    localparam int EN_BRACKET = 0;
    localparam int EN_DOT     = 1;
    localparam int EN_SPACE   = 2;
    localparam int EN_PAREN   = 3;
    localparam int EN_AMP     = 4;
    localparam int EN_SEP     = 5;

    // repair mask bits
    localparam logic [5:0] REP_CASE  = 6'h01;
    localparam logic [5:0] REP_CHARS = 6'h02;
    localparam logic [5:0] REP_SEPS  = 6'h04;
    localparam logic [5:0] REP_UNDER = 6'h08;
    localparam logic [5:0] REP_LEN   = 6'h10;
    localparam logic [5:0] REP_EMPTY = 6'h20;

    // characters
    localparam logic [7:0] CH_BSL   = 8'h5C;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_US    = 8'h5F;
    localparam logic [7:0] CH_DASH  = 8'h2D;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_SP    = 8'h20;
    localparam logic [7:0] CH_LBRK  = 8'h5B;
    localparam logic [7:0] CH_RBRK  = 8'h5D;
    localparam logic [7:0] CH_LPAR  = 8'h28;
    localparam logic [7:0] CH_RPAR  = 8'h29;
    localparam logic [7:0] CH_AMP   = 8'h26;
    localparam logic [7:0] CASE_OFS = 8'h20;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] char_code;
    } t_in;

    typedef struct packed {
        logic [7:0] out_char;
        logic       out_last;
        logic       out_empty;
        logic [5:0] repair_mask;
    } t_out;

    typedef struct packed {
        logic [5:0] char_class_enables;
        logic       lower_case_only;
        logic       allow_empty_name;
        logic [6:0] length_limit;
    } t_cfg;

    // classified item handed from front to back
    typedef struct packed {
        logic [7:0] ch;        // after backslash map and case fold
        logic       has_char;
        logic       is_final;
        logic       is_sep;
        logic       allowed;
        logic [5:0] rep;
    } t_cls;

    function automatic logic [7:0] unnamed_char(input logic [2:0] k);
        logic [7:0] c;
        case (k)
            3'd0:    c = 8'h75;  // u
            3'd1:    c = 8'h6E;  // n
            3'd2:    c = 8'h6E;  // n
            3'd3:    c = 8'h61;  // a
            3'd4:    c = 8'h6D;  // m
            3'd5:    c = 8'h65;  // e
            3'd6:    c = 8'h64;  // d
            default: c = 8'h00;
        endcase
        return c;
    endfunction

endpackage

FILE: hw/rtl/identifier_normalizer_top.sv
// identifier_normalizer_top: configuration registers, front classifier, item
// queue and back sequencer. Depends on idn_pkg, idn_front, idn_fifo, idn_back.
// Back sequence: a character item is dequeued, then executed; each byte trimmed
//   before a separator or at the end adds a pop and a buffer read.
// Flow: the back sequencer takes a new input item only when done with the last one;
//   results leave one byte at a time through the registered buffer read port, as the output allows.
// Reset: synchronous, active low; control registers return to reset values and
//   the name buffer is never cleared (only bytes written for the current name are read).
module identifier_normalizer_top (
    input  logic              i_clk,
    input  logic              i_rst_n,
    // input items
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  idn_pkg::t_in      i_in,
    // result items
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output idn_pkg::t_out     o_out,
    // configuration writes
    input  logic              i_cfg_we,
    input  logic [1:0]        i_cfg_idx,
    input  logic [6:0]        i_cfg_data
);
    import idn_pkg::*;

    // Configuration registers. The user must write them only while the block is idle,
    // so the front and back see stable values for a whole name; the block does not enforce this.
    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.char_class_enables <= '0;
            r_cfg.lower_case_only    <= 1'b0;
            r_cfg.allow_empty_name   <= 1'b0;
            r_cfg.length_limit       <= 7'd64;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_CLASS: r_cfg.char_class_enables <= i_cfg_data[5:0];
                CFG_LOWER: r_cfg.lower_case_only    <= i_cfg_data[0];
                CFG_EMPTY: r_cfg.allow_empty_name   <= i_cfg_data[0];
                CFG_LIMIT: r_cfg.length_limit       <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // Front: classifies each byte (backslash map, case fold, allowed set)
    // and pushes it into the queue; reserved kinds are taken and dropped.
    logic q_push;
    logic q_full;
    logic q_empty;
    logic q_pop;
    t_cls q_wdata;
    t_cls q_rdata;

    idn_front u_front (
        .i_in_valid (i_in_valid),
        .i_in       (i_in),
        .i_cfg      (r_cfg),
        .i_full     (q_full),
        .o_in_ready (o_in_ready),
        .o_push     (q_push),
        .o_cls      (q_wdata)
    );

    // Two-entry queue lets the front keep taking items while the back trims
    // or emits.
    idn_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  (q_wdata),
        .i_pop   (q_pop),
        .o_full  (q_full),
        .o_empty (q_empty),
        .o_data  (q_rdata)
    );

    // Back: edits the name buffer, runs the trim passes and streams the result
    // through its output register.
    idn_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_q_empty   (q_empty),
        .i_q_data    (q_rdata),
        .o_q_pop     (q_pop),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out       (o_out)
    );
endmodule

FILE: hw/rtl/idn_ram.sv
// idn_ram: generic single-write, single-read RAM with registered read data.
// No dependencies.
module idn_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

FILE: hw/rtl/idn_front.sv
// idn_front: accepts input items and classifies each character.
// Depends on idn_pkg; feeds idn_fifo.
module idn_front (
    input  logic          i_in_valid,
    input  idn_pkg::t_in  i_in,
    input  idn_pkg::t_cfg i_cfg,
    input  logic          i_full,
    output logic          o_in_ready,
    output logic          o_push,
    output idn_pkg::t_cls o_cls
);
    import idn_pkg::*;

    logic [7:0] c;
    logic [5:0] rep;
    logic       sep_en;
    logic       sep;
    logic       ok;
    logic [5:0] en;

    always_comb begin
        en     = i_cfg.char_class_enables;
        sep_en = en[EN_SEP];
        c      = i_in.char_code;
        rep    = '0;
        if (c == CH_BSL && sep_en) begin
            c   = CH_SLASH;
            rep = rep | REP_SEPS;
        end
        sep = (c == CH_SLASH) && sep_en;
        if (!sep && i_cfg.lower_case_only && c inside {[8'h41:8'h5A]}) begin
            c   = c + CASE_OFS;
            rep = rep | REP_CASE;
        end
        ok = (c inside {[8'h41:8'h5A], [8'h61:8'h7A], [8'h30:8'h39]})
           || c == CH_US || c == CH_DASH
           || (en[EN_BRACKET] && (c == CH_LBRK || c == CH_RBRK))
           || (en[EN_DOT]     && c == CH_DOT)
           || (en[EN_SPACE]   && c == CH_SP)
           || (en[EN_PAREN]   && (c == CH_LPAR || c == CH_RPAR))
           || (en[EN_AMP]     && c == CH_AMP);

        o_cls.ch       = c;
        o_cls.has_char = (i_in.kind == KIND_CHAR) || (i_in.kind == KIND_FINAL);
        o_cls.is_final = (i_in.kind == KIND_FINAL) || (i_in.kind == KIND_END);
        o_cls.is_sep   = sep;
        o_cls.allowed  = ok;
        // end of empty name carries no byte, so no repairs from its code
        o_cls.rep      = (i_in.kind == KIND_END) ? 6'd0 : rep;
    end

    // reserved kind is taken and dropped
    assign o_in_ready = !i_full;
    assign o_push     = i_in_valid && !i_full && (i_in.kind != KIND_RSVD);
endmodule

FILE: hw/rtl/idn_fifo.sv
// idn_fifo: short queue of classified items between front and back.
// Depends on idn_pkg.
module idn_fifo (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  idn_pkg::t_cls i_data,
    input  logic          i_pop,
    output logic          o_full,
    output logic          o_empty,
    output idn_pkg::t_cls o_data
);
    import idn_pkg::*;

    t_cls            r_mem [Q_DEPTH];
    logic [Q_AW-1:0] r_wptr;
    logic [Q_AW-1:0] r_rptr;
    logic [Q_CW-1:0] r_cnt;
    logic            do_push;
    logic            do_pop;

    assign o_full  = (r_cnt == Q_CW'(Q_DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_data  = r_mem[r_rptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wptr] <= i_data;
        end
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_rptr <= '0;
            r_cnt  <= '0;
        end else begin
            if (do_push) begin
                r_wptr <= r_wptr + Q_AW'(1);
            end
            if (do_pop) begin
                r_rptr <= r_rptr + Q_AW'(1);
            end
            r_cnt <= r_cnt + Q_CW'(do_push) - Q_CW'(do_pop);
        end
    end
endmodule

FILE: hw/rtl/idn_back.sv
// idn_back: sequencer that edits the name buffer, trims and emits results.
// Depends on idn_pkg and idn_ram; takes items from idn_fifo.
module idn_back (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  idn_pkg::t_cfg i_cfg,
    input  logic          i_q_empty,
    input  idn_pkg::t_cls i_q_data,
    output logic          o_q_pop,
    output logic          o_out_valid,
    input  logic          i_out_ready,
    output idn_pkg::t_out o_out
);
    import idn_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE, S_EXEC, S_RD, S_FIN, S_EMIT, S_ELOAD, S_EMPTY
    } t_state;

    t_state            r_state, n_state;
    t_cls              r_cur, n_cur;
    logic              r_ret_fin, n_ret_fin;
    logic [CNT_W-1:0]  r_fill, n_fill;
    logic              r_seg, n_seg;
    logic              r_us, n_us;
    logic              r_arep, n_arep;
    logic [5:0]        r_rep, n_rep;
    logic [7:0]        r_last, n_last;
    logic              r_unn, n_unn;
    logic [ADDR_W-1:0] r_idx, n_idx;
    logic              r_ov, n_ov;
    t_out              r_out, n_out;

    logic              ram_we;
    logic [ADDR_W-1:0] ram_waddr;
    logic [7:0]        ram_wdata;
    logic [ADDR_W-1:0] ram_raddr;
    logic [7:0]        ram_rdata;

    logic [CNT_W-1:0]  lim_eff;
    logic [CNT_W-1:0]  unn_len;
    logic [CNT_W-1:0]  fill_m1;
    logic [CNT_W-1:0]  fill_m2;
    logic              full;
    logic              sp_en;
    logic              has_last;
    logic              out_free;
    logic              emit_last;
    logic [7:0]        ch;
    logic              drop;
    logic [5:0]        rep_add;
    logic              c_seg, c_us, c_arep;

    idn_ram #(.WIDTH(8), .DEPTH(MAX_LEN)) u_buf (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // effective limit: zero reads as one, saturates at the buffer size
    always_comb begin
        if (i_cfg.length_limit == '0) begin
            lim_eff = CNT_W'(1);
        end else if (int'(i_cfg.length_limit) > MAX_LEN) begin
            lim_eff = CNT_W'(MAX_LEN);
        end else begin
            lim_eff = CNT_W'(i_cfg.length_limit);
        end
        unn_len = (lim_eff > CNT_W'(UNNAMED_LEN)) ? CNT_W'(UNNAMED_LEN) : lim_eff;
    end

    assign fill_m1   = r_fill - CNT_W'(1);
    assign fill_m2   = r_fill - CNT_W'(2);
    assign full      = (r_fill >= lim_eff);
    assign sp_en     = i_cfg.char_class_enables[EN_SPACE];
    assign has_last  = (r_fill != '0);
    assign out_free  = !r_ov || i_out_ready;
    assign emit_last = ((CNT_W'(r_idx) + CNT_W'(1)) == r_fill);

    // plain character path
    always_comb begin
        ch      = r_cur.ch;
        drop    = 1'b0;
        rep_add = '0;
        c_seg   = r_seg;
        c_us    = r_us;
        c_arep  = r_arep;
        if (!r_cur.allowed) begin
            rep_add = rep_add | REP_CHARS;
            if (r_arep) begin
                drop = 1'b1;
            end else begin
                ch     = CH_DASH;
                c_arep = 1'b1;
            end
        end else begin
            c_arep = 1'b0;
        end
        if (!drop) begin
            if (ch == CH_DOT && r_seg) begin
                ch      = CH_DASH;
                rep_add = rep_add | REP_CHARS;
            end
            if (ch == CH_US) begin
                if (r_seg || r_us) begin
                    rep_add = rep_add | REP_UNDER;
                    drop    = 1'b1;
                end else begin
                    c_us = 1'b1;
                end
            end else begin
                c_seg = 1'b0;
                c_us  = 1'b0;
            end
            if (!drop && full) begin
                rep_add = rep_add | REP_LEN;
                drop    = 1'b1;
            end
        end
    end

    always_comb begin
        n_state   = r_state;
        n_cur     = r_cur;
        n_ret_fin = r_ret_fin;
        n_fill    = r_fill;
        n_seg     = r_seg;
        n_us      = r_us;
        n_arep    = r_arep;
        n_rep     = r_rep;
        n_last    = r_last;
        n_unn     = r_unn;
        n_idx     = r_idx;
        n_ov      = r_ov;
        n_out     = r_out;
        ram_we    = 1'b0;
        ram_waddr = r_fill[ADDR_W-1:0];
        ram_wdata = ch;
        ram_raddr = r_idx;
        o_q_pop   = 1'b0;
        if (r_ov && i_out_ready) begin
            n_ov = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (!i_q_empty) begin
                    o_q_pop = 1'b1;
                    n_cur   = i_q_data;
                    n_rep   = r_rep | i_q_data.rep;
                    n_state = i_q_data.has_char ? S_EXEC : S_FIN;
                end
            end
            S_EXEC: begin
                if (r_cur.is_sep) begin
                    if (has_last && (r_last == CH_US || (sp_en && r_last == CH_SP))) begin
                        n_rep     = r_rep | ((r_last == CH_US) ? REP_UNDER : REP_CHARS);
                        n_fill    = fill_m1;
                        ram_raddr = fill_m2[ADDR_W-1:0];
                        n_ret_fin = 1'b0;
                        n_state   = S_RD;
                    end else if (has_last && r_last == CH_DOT) begin
                        ram_we    = 1'b1;
                        ram_waddr = fill_m1[ADDR_W-1:0];
                        ram_wdata = CH_DASH;
                        n_last    = CH_DASH;
                        n_rep     = r_rep | REP_CHARS;
                    end else begin
                        if (!has_last || r_last == CH_SLASH) begin
                            n_rep = r_rep | REP_SEPS;
                        end else if (full) begin
                            n_rep = r_rep | REP_LEN;
                        end else begin
                            ram_we    = 1'b1;
                            ram_wdata = CH_SLASH;
                            n_fill    = r_fill + CNT_W'(1);
                            n_last    = CH_SLASH;
                            n_seg     = 1'b1;
                            n_us      = 1'b0;
                            n_arep    = 1'b0;
                        end
                        n_state = r_cur.is_final ? S_FIN : S_IDLE;
                    end
                end else begin
                    n_rep  = r_rep | rep_add;
                    n_seg  = c_seg;
                    n_us   = c_us;
                    n_arep = c_arep;
                    if (!drop) begin
                        ram_we = 1'b1;
                        n_fill = r_fill + CNT_W'(1);
                        n_last = ch;
                    end
                    n_state = r_cur.is_final ? S_FIN : S_IDLE;
                end
            end
            S_RD: begin
                n_last  = ram_rdata;
                n_state = r_ret_fin ? S_FIN : S_EXEC;
            end
            S_FIN: begin
                if (has_last && (r_last == CH_US || r_last == CH_SLASH
                                 || (sp_en && r_last == CH_SP))) begin
                    n_rep     = r_rep | ((r_last == CH_US) ? REP_UNDER :
                                         (r_last == CH_SLASH) ? REP_SEPS : REP_CHARS);
                    n_fill    = fill_m1;
                    ram_raddr = fill_m2[ADDR_W-1:0];
                    n_ret_fin = 1'b1;
                    n_state   = S_RD;
                end else if (has_last && r_last == CH_DOT) begin
                    ram_we    = 1'b1;
                    ram_waddr = fill_m1[ADDR_W-1:0];
                    ram_wdata = CH_DASH;
                    n_last    = CH_DASH;
                    n_rep     = r_rep | REP_CHARS;
                end else if (!has_last && !i_cfg.allow_empty_name) begin
                    n_fill  = unn_len;
                    n_unn   = 1'b1;
                    n_rep   = r_rep | REP_EMPTY;
                    n_idx   = '0;
                    n_state = S_EMIT;
                end else if (!has_last) begin
                    n_state = S_EMPTY;
                end else begin
                    n_idx   = '0;
                    n_state = S_EMIT;
                end
            end
            S_EMIT: begin
                if (out_free) begin
                    n_state = S_ELOAD;
                end
            end
            S_ELOAD: begin
                n_ov                = 1'b1;
                n_out.out_char      = r_unn ? unnamed_char(r_idx[2:0]) : ram_rdata;
                n_out.out_last      = emit_last;
                n_out.out_empty     = 1'b0;
                n_out.repair_mask   = emit_last ? r_rep : '0;
                n_idx               = r_idx + ADDR_W'(1);
                if (emit_last) begin
                    n_fill  = '0;
                    n_seg   = 1'b1;
                    n_us    = 1'b0;
                    n_arep  = 1'b0;
                    n_rep   = '0;
                    n_unn   = 1'b0;
                    n_state = S_IDLE;
                end else begin
                    n_state = S_EMIT;
                end
            end
            S_EMPTY: begin
                if (out_free) begin
                    n_ov              = 1'b1;
                    n_out.out_char    = '0;
                    n_out.out_last    = 1'b1;
                    n_out.out_empty   = 1'b1;
                    n_out.repair_mask = r_rep;
                    n_seg             = 1'b1;
                    n_us              = 1'b0;
                    n_arep            = 1'b0;
                    n_rep             = '0;
                    n_state           = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_cur     <= n_cur;
        r_last    <= n_last;
        r_idx     <= n_idx;
        r_out     <= n_out;
        r_ret_fin <= n_ret_fin;
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_fill  <= '0;
            r_seg   <= 1'b1;
            r_us    <= 1'b0;
            r_arep  <= 1'b0;
            r_rep   <= '0;
            r_unn   <= 1'b0;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_fill  <= n_fill;
            r_seg   <= n_seg;
            r_us    <= n_us;
            r_arep  <= n_arep;
            r_rep   <= n_rep;
            r_unn   <= n_unn;
            r_ov    <= n_ov;
        end
    end

    assign o_out_valid = r_ov;
    assign o_out       = r_out;

    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= CNT_W'(MAX_LEN))
        else $error("fill count beyond buffer size");

    a_load_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_ELOAD) |-> !r_ov)
        else $error("output register overwritten");

    a_clear_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_ELOAD && emit_last) |=> (r_fill == '0 && r_rep == '0))
        else $error("name state not cleared after last item");

    a_empty_only_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EMPTY) |-> (r_fill == '0 && i_cfg.allow_empty_name))
        else $error("empty result with buffered bytes");
endmodule

FILE: tb/identifier_normalizer_top_tb.sv
// identifier_normalizer_top_tb: self-checking testbench for the identifier normalizer.
// Needs idn_pkg and identifier_normalizer_top. A built-in predictor rebuilds each name
// and checks every output byte and the repair mask on the last byte.
module identifier_normalizer_top_tb;
    import idn_pkg::*;

    localparam int    WATCHDOG_LIMIT = 4000;  // cycles with no handshake at all
    localparam int    SETTLE_CYCLES  = 200;   // covers the worst trim run, a pop and buffer read per buffered byte
    localparam int    TAIL_CYCLES    = 50;
    localparam int    IDLE_PCT       = 32;
    localparam string UNNAMED_WORD   = "unnamed";

    logic   i_clk = 1'b0;
    logic   i_rst_n;
    logic   i_in_valid;
    logic   o_in_ready;
    t_in    i_in;
    logic   o_out_valid;
    logic   i_out_ready;
    t_out   o_out;
    logic   i_cfg_we;
    logic [1:0] i_cfg_idx;
    logic [6:0] i_cfg_data;

    identifier_normalizer_top dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in        (i_in),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out       (o_out),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    // ------------------------------------------------------------------
    // Predictor state: its own copy of the registers and of the name
    // being built. Only bytes below name_len are ever read.
    // ------------------------------------------------------------------
    logic [5:0] class_en;
    logic       fold_lower;
    logic       empty_ok;
    logic [6:0] len_limit;

    logic [7:0] name_buf [MAX_LEN];
    int         name_len;
    logic       seg_start;
    logic       prev_underscore;
    logic       prev_replaced;
    logic [5:0] repairs;

    t_out       expected_bytes [$];   // normalized bytes still owed by the block
    t_out       want;
    int         errors;
    int         quiet_cycles;
    logic       steady;               // 1: neither side idles

    function automatic int cap_length();
        int lim;
        lim = len_limit;
        if (lim == 0)       lim = 1;
        if (lim > MAX_LEN)  lim = MAX_LEN;
        return lim;
    endfunction

    function automatic logic char_ok(input logic [7:0] c);
        if (c >= "A" && c <= "Z") return 1'b1;
        if (c >= "a" && c <= "z") return 1'b1;
        if (c >= "0" && c <= "9") return 1'b1;
        if (c == CH_US || c == CH_DASH) return 1'b1;
        if (class_en[EN_BRACKET] && (c == CH_LBRK || c == CH_RBRK)) return 1'b1;
        if (class_en[EN_DOT] && c == CH_DOT) return 1'b1;
        if (class_en[EN_SPACE] && c == CH_SP) return 1'b1;
        if (class_en[EN_PAREN] && (c == CH_LPAR || c == CH_RPAR)) return 1'b1;
        if (class_en[EN_AMP] && c == CH_AMP) return 1'b1;
        return 1'b0;
    endfunction

    function automatic logic [7:0] tail_byte();
        return name_buf[name_len - 1];
    endfunction

    function automatic void clear_name_state();
        name_len        = 0;
        seg_start       = 1'b1;
        prev_underscore = 1'b0;
        prev_replaced   = 1'b0;
        repairs         = '0;
    endfunction

    // One character into the name under construction.
    function automatic void absorb_char(input logic [7:0] raw);
        logic [7:0] c;
        int         lim;
        logic       seps;
        c    = raw;
        lim  = cap_length();
        seps = class_en[EN_SEP];
        if (c == CH_BSL && seps) begin
            c = CH_SLASH;
            repairs |= REP_SEPS;
        end
        if (c == CH_SLASH && seps) begin
            // trim underscores (and spaces if allowed) before the separator
            while (name_len > 0 && (tail_byte() == CH_US ||
                   (class_en[EN_SPACE] && tail_byte() == CH_SP))) begin
                repairs |= (tail_byte() == CH_US) ? REP_UNDER : REP_CHARS;
                name_len--;
            end
            if (name_len > 0 && tail_byte() == CH_DOT) begin
                name_buf[name_len - 1] = CH_DASH;
                repairs |= REP_CHARS;
            end
            if (name_len == 0 || tail_byte() == CH_SLASH) begin
                repairs |= REP_SEPS;
                return;
            end
            if (name_len >= lim) begin
                repairs |= REP_LEN;
                return;
            end
            name_buf[name_len] = CH_SLASH;
            name_len++;
            seg_start       = 1'b1;
            prev_underscore = 1'b0;
            prev_replaced   = 1'b0;
            return;
        end
        if (fold_lower && c >= "A" && c <= "Z") begin
            c = c + CASE_OFS;
            repairs |= REP_CASE;
        end
        if (!char_ok(c)) begin
            repairs |= REP_CHARS;
            if (prev_replaced) return;
            c = CH_DASH;
            prev_replaced = 1'b1;
        end else begin
            prev_replaced = 1'b0;
        end
        if (c == CH_DOT && seg_start) begin
            c = CH_DASH;
            repairs |= REP_CHARS;
        end
        if (c == CH_US) begin
            if (seg_start || prev_underscore) begin
                repairs |= REP_UNDER;
                return;
            end
            prev_underscore = 1'b1;
        end else begin
            seg_start       = 1'b0;
            prev_underscore = 1'b0;
        end
        if (name_len >= lim) begin
            repairs |= REP_LEN;
            return;
        end
        name_buf[name_len] = c;
        name_len++;
    endfunction

    // Close the name and queue every byte it will produce.
    function automatic void close_name();
        logic [7:0] b;
        int         n;
        t_out       r;
        while (name_len > 0 && (tail_byte() == CH_US || tail_byte() == CH_SLASH ||
               (class_en[EN_SPACE] && tail_byte() == CH_SP))) begin
            b = tail_byte();
            repairs |= (b == CH_US) ? REP_UNDER : (b == CH_SLASH) ? REP_SEPS : REP_CHARS;
            name_len--;
        end
        if (name_len > 0 && tail_byte() == CH_DOT) begin
            name_buf[name_len - 1] = CH_DASH;
            repairs |= REP_CHARS;
        end
        if (name_len == 0 && !empty_ok) begin
            n = (cap_length() > UNNAMED_LEN) ? UNNAMED_LEN : cap_length();
            for (int i = 0; i < n; i++) name_buf[i] = UNNAMED_WORD[i];
            name_len = n;
            repairs |= REP_EMPTY;
        end
        if (name_len == 0) begin
            r.out_char    = '0;
            r.out_last    = 1'b1;
            r.out_empty   = 1'b1;
            r.repair_mask = repairs;
            expected_bytes.insert(expected_bytes.size(), r);
        end else begin
            for (int i = 0; i < name_len; i++) begin
                r.out_char    = name_buf[i];
                r.out_last    = (i == name_len - 1);
                r.out_empty   = 1'b0;
                r.repair_mask = (i == name_len - 1) ? repairs : 6'd0;
                expected_bytes.insert(expected_bytes.size(), r);
            end
        end
        clear_name_state();
    endfunction

    // ------------------------------------------------------------------
    // Result side: random backpressure and the byte checker.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        i_out_ready <= i_rst_n && (steady || $urandom_range(99) >= IDLE_PCT);
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (expected_bytes.size() == 0) begin
                errors++;
                if (errors <= 10)
                    $display("unexpected byte: char=%h last=%b empty=%b mask=%h",
                             o_out.out_char, o_out.out_last, o_out.out_empty,
                             o_out.repair_mask);
            end else begin
                want = expected_bytes.pop_front();
                if (o_out.out_char !== want.out_char || o_out.out_last !== want.out_last ||
                    o_out.out_empty !== want.out_empty ||
                    o_out.repair_mask !== want.repair_mask) begin
                    errors++;
                    if (errors <= 10)
                        $display({"mismatch: exp char=%h last=%b empty=%b mask=%h",
                                  " / got char=%h last=%b empty=%b mask=%h"},
                                 want.out_char, want.out_last, want.out_empty,
                                 want.repair_mask, o_out.out_char, o_out.out_last,
                                 o_out.out_empty, o_out.repair_mask);
                end
            end
        end
    end

    // Watchdog: any handshake on either side restarts the count.
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no handshake for %0d cycles", WATCHDOG_LIMIT);
            $display("RESULT: ERROR");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // ------------------------------------------------------------------
    // Shared driver tasks. Every task starts and ends on a rising edge.
    // ------------------------------------------------------------------

    // Send one item; the predictor runs first, items are accepted in order.
    task automatic send_item(input logic [1:0] kind, input logic [7:0] code);
        case (kind)
            KIND_CHAR:  absorb_char(code);
            KIND_FINAL: begin
                absorb_char(code);
                close_name();
            end
            KIND_END:   close_name();
            default:    ;  // reserved kind: block ignores it
        endcase
        if (!steady) begin
            while ($urandom_range(99) < IDLE_PCT) begin
                i_in_valid <= 1'b0;
                @(posedge i_clk);
            end
        end
        i_in_valid     <= 1'b1;
        i_in.kind      <= kind;
        i_in.char_code <= code;
        do @(posedge i_clk); while (!o_in_ready);
    endtask

    // Drain: all bytes out, then room for trailing no-result items to finish.
    task automatic settle();
        i_in_valid <= 1'b0;
        while (expected_bytes.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Write all four registers back to back; only called while idle.
    task automatic load_config(input logic [5:0] cls, input logic lower,
                               input logic empty, input logic [6:0] limit);
        class_en   = cls;
        fold_lower = lower;
        empty_ok   = empty;
        len_limit  = limit;
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= CFG_CLASS;
        i_cfg_data <= {1'b0, cls};
        @(posedge i_clk);
        i_cfg_idx  <= CFG_LOWER;
        i_cfg_data <= {6'd0, lower};
        @(posedge i_clk);
        i_cfg_idx  <= CFG_EMPTY;
        i_cfg_data <= {6'd0, empty};
        @(posedge i_clk);
        i_cfg_idx  <= CFG_LIMIT;
        i_cfg_data <= limit;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
    endtask

    // Weighted character mix: mostly legal text, plenty of separators,
    // dots, underscores and class characters, some raw bytes.
    function automatic logic [7:0] pick_char();
        int roll;
        roll = $urandom_range(99);
        if (roll < 30) return 8'(($urandom_range(1) ? "a" : "A") + $urandom_range(25));
        if (roll < 40) return 8'("0" + $urandom_range(9));
        if (roll < 52) return CH_US;
        if (roll < 58) return CH_DASH;
        if (roll < 66) return CH_DOT;
        if (roll < 72) return CH_SP;
        if (roll < 80) return CH_SLASH;
        if (roll < 84) return CH_BSL;
        if (roll < 88) return $urandom_range(1) ? CH_LBRK : CH_RBRK;
        if (roll < 91) return $urandom_range(1) ? CH_LPAR : CH_RPAR;
        if (roll < 93) return CH_AMP;
        return 8'($urandom_range(255));
    endfunction

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Reserved kind is dropped; empty name gives "unnamed", or the empty
    // marker once empty names are allowed.
    task automatic test_empty_names();
        send_item(KIND_RSVD, 8'hFF);
        send_item(KIND_END, 8'h00);
        settle();
        load_config(6'd0, 1'b0, 1'b1, 7'd64);
        send_item(KIND_END, 8'hA5);
        settle();
    endtask

    // All classes on with case folding: backslash map, leading underscore,
    // trim before a separator, dot before separator and at the end, high bytes.
    task automatic test_repair_paths();
        load_config(6'h3F, 1'b1, 1'b0, 7'd64);
        send_item(KIND_CHAR, CH_US);
        send_item(KIND_CHAR, CH_BSL);
        send_item(KIND_CHAR, "A");
        send_item(KIND_CHAR, CH_DOT);
        send_item(KIND_CHAR, CH_SP);
        send_item(KIND_CHAR, CH_US);
        send_item(KIND_CHAR, CH_SLASH);
        send_item(KIND_CHAR, CH_LPAR);
        send_item(KIND_CHAR, CH_AMP);
        send_item(KIND_CHAR, CH_RBRK);
        send_item(KIND_CHAR, 8'h80);
        send_item(KIND_CHAR, CH_DOT);
        send_item(KIND_FINAL, CH_SP);
        settle();
    endtask

    // Limit zero acts as one, limit above the buffer saturates; doubled
    // underscores and a run of disallowed bytes.
    task automatic test_length_cap();
        load_config(6'd0, 1'b0, 1'b0, 7'd0);
        send_item(KIND_CHAR, "a");
        send_item(KIND_CHAR, CH_US);
        send_item(KIND_CHAR, CH_US);
        send_item(KIND_CHAR, 8'h00);
        send_item(KIND_CHAR, 8'hFF);
        send_item(KIND_FINAL, "Z");
        settle();
        load_config(6'd0, 1'b0, 1'b0, 7'd127);
        send_item(KIND_END, 8'h00);
        settle();
    endtask

    // Random well-formed names with random content, a few reserved items
    // mixed in, under one register setting.
    task automatic test_random_names(input int budget);
        int   sent;
        int   len;
        logic ends_on_char;
        sent = 0;
        while (sent < budget) begin
            len = ($urandom_range(99) < 92) ? $urandom_range(12) : $urandom_range(75, 50);
            ends_on_char = ($urandom_range(99) < 80);
            for (int k = 0; k < len; k++) begin
                if ($urandom_range(99) < 5) send_item(KIND_RSVD, 8'($urandom_range(255)));
                if (k == len - 1 && ends_on_char) send_item(KIND_FINAL, pick_char());
                else send_item(KIND_CHAR, pick_char());
                sent++;
            end
            if (len == 0 || !ends_on_char) begin
                send_item(KIND_END, 8'($urandom_range(255)));
                sent++;
            end
        end
        settle();
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial begin
        errors = 0;
        steady <= 1'b0;
        i_rst_n    <= 1'b0;
        i_in_valid <= 1'b0;
        i_in       <= '0;
        i_out_ready <= 1'b0;
        i_cfg_we   <= 1'b0;
        i_cfg_idx  <= CFG_CLASS;
        i_cfg_data <= '0;
        // predictor mirrors the reset values of the registers and the name
        class_en   = 6'd0;
        fold_lower = 1'b0;
        empty_ok   = 1'b0;
        len_limit  = 7'd64;
        clear_name_state();
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_empty_names();
        test_repair_paths();
        test_length_cap();

        // random phases; short limits make truncation common
        load_config(6'($urandom_range(63)), 1'($urandom_range(1)), 1'($urandom_range(1)),
                    7'($urandom_range(12, 1)));
        test_random_names(36);
        steady <= 1'b1;   // long stretch with no idling on either side
        load_config(6'h3F, 1'b1, 1'b1, 7'd127);
        test_random_names(36);
        steady <= 1'b0;
        load_config(6'd0, 1'b0, 1'b0, 7'd0);
        test_random_names(36);
        load_config(6'($urandom_range(63)), 1'($urandom_range(1)), 1'($urandom_range(1)),
                    7'd64);
        test_random_names(36);
        load_config(6'h3F, 1'b0, 1'b0, 7'd64);
        test_random_names(36);
        load_config(6'($urandom_range(63)), 1'($urandom_range(1)), 1'($urandom_range(1)),
                    7'($urandom_range(127)));
        test_random_names(36);

        i_in_valid <= 1'b0;
        while (expected_bytes.size() != 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);
        errors += expected_bytes.size();
        if (errors == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
